// ===== design/spot_pkg.sv =====
`default_nettype none
package spot_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TRIG_FRAC_DEF  = 14;

	// body descriptor layout
	localparam int DESC_W    = 17;
	localparam int SHAPE_BIT = 0;
	localparam int SELF_LO   = 1;
	localparam int HIT_LO    = 9;
	localparam int MASK_W    = 8;

	// angles in whole degrees
	localparam int ANG_W    = 9;
	localparam int ANG_FULL = 360;
	localparam int ANG_HALF = 180;
	localparam int ANG_QTR  = 90;
	localparam int QDEG_W   = 7;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		CLS_CC,
		CLS_RR,
		CLS_CR
	} cls_t;

	typedef struct packed {
		logic valid;
		logic mask_ok;
		cls_t cls;
	} ctl_t;

	// sin magnitude of deg (0..90) at fb fraction bits; elaboration only
	// series terms divide by (2k)(2k+1) for k = 1..6
	function automatic longint unsigned trig_mag(input int deg, input int fb);
		longint unsigned x, x2, term, sum, d64;
		d64 = deg;
		x = (d64 * PI_Q30) / 64'd180;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + term;
		sum = (sum + (64'd1 << (29 - fb))) >> (30 - fb);
		return sum;
	endfunction

endpackage
`default_nettype wire

// ===== design/spot_trig.sv =====
`default_nettype none
module spot_trig
	import spot_pkg::*;
#(
	parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
	input  logic [ANG_W-1:0]                    angle,
	output logic signed [TRIG_FRACTION_BITS+1:0] sine,
	output logic signed [TRIG_FRACTION_BITS+1:0] cosine,
	output logic                                 is_zero
);
	localparam int F  = TRIG_FRACTION_BITS;
	localparam int MW = F + 1;
	localparam int TW = F + 2;

	logic [MW-1:0] mag_tab [0:ANG_QTR];

	genvar g;
	for (g = 0; g <= ANG_QTR; g++) begin : g_tab
		assign mag_tab[g] = MW'(trig_mag(g, F));
	end

	// {negate, 0..90}
	function automatic logic [QDEG_W:0] fold_deg(input logic [ANG_W-1:0] d);
		logic [ANG_W-1:0] q;
		logic neg;
		q = d;
		neg = 1'b0;
		if (q >= ANG_W'(ANG_HALF)) begin
			q = q - ANG_W'(ANG_HALF);
			neg = 1'b1;
		end
		if (q > ANG_W'(ANG_QTR)) q = ANG_W'(ANG_HALF) - q;
		return {neg, q[QDEG_W-1:0]};
	endfunction

	logic [ANG_W-1:0]  ang_n, ang_c;
	logic [QDEG_W:0]   fs, fc;
	logic signed [TW-1:0] ms, mc;

	always_comb begin
		ang_n = (angle >= ANG_W'(ANG_FULL)) ? angle - ANG_W'(ANG_FULL) : angle;
		ang_c = ang_n + ANG_W'(ANG_QTR);
		if (ang_c >= ANG_W'(ANG_FULL)) ang_c = ang_c - ANG_W'(ANG_FULL);
		fs = fold_deg(ang_n);
		fc = fold_deg(ang_c);
		ms = $signed({1'b0, mag_tab[fs[QDEG_W-1:0]]});
		mc = $signed({1'b0, mag_tab[fc[QDEG_W-1:0]]});
		sine    = fs[QDEG_W] ? -ms : ms;
		cosine  = fc[QDEG_W] ? -mc : mc;
		is_zero = (ang_n == '0);
	end

endmodule
`default_nettype wire

// ===== design/spot_rect.sv =====
`default_nettype none
module spot_rect
	import spot_pkg::*;
#(
	parameter int COORD_BITS         = COORD_BITS_DEF,
	parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic signed [COORD_BITS:0]           dx,
	input  logic signed [COORD_BITS:0]           dy,
	input  logic [COORD_BITS-2:0]                wa,
	input  logic [COORD_BITS-2:0]                ha,
	input  logic [COORD_BITS-2:0]                wb,
	input  logic [COORD_BITS-2:0]                hb,
	input  logic signed [TRIG_FRACTION_BITS+1:0] ca,
	input  logic signed [TRIG_FRACTION_BITS+1:0] sa,
	input  logic signed [TRIG_FRACTION_BITS+1:0] cb,
	input  logic signed [TRIG_FRACTION_BITS+1:0] sb,
	input  logic                                 aligned,
	output logic                                 touch
);
	localparam int N    = COORD_BITS;
	localparam int F    = TRIG_FRACTION_BITS;
	localparam int AW   = N + F + 2;
	localparam int NDW  = AW + N + 1;
	localparam int NNW  = 2 * AW;
	localparam int SEPW = 2 * AW + 2;

	// normals: 0 = a.X, 1 = a.Y, 2 = b.X, 3 = b.Y
	logic signed [AW-1:0]   nx_s2 [4];
	logic signed [AW-1:0]   ny_s2 [4];
	logic signed [N:0]      dx_s2, dy_s2;
	logic                   al_s2, box_s2;

	logic signed [NDW-1:0]  ndx_s3 [4], ndy_s3 [4];
	logic signed [NNW-1:0]  nnx_s3 [4], nny_s3 [4];
	logic signed [NNW-1:0]  cpx_s3 [4], cpy_s3 [4];
	logic                   al_s3, box_s3;

	logic signed [NDW:0]    nd_s4 [4];
	logic signed [NNW:0]    nn_s4 [4];
	logic signed [NNW:0]    cp_s4 [4];
	logic                   al_s4, box_s4;

	logic signed [SEPW-1:0] t_s5 [4], s_s5 [4];
	logic                   al_s5, box_s5;

	logic                   touch_s6;

	logic [N:0]   adx, ady;
	logic [N+1:0] lhs_x, lhs_y, rhs_x, rhs_y;

	always_comb begin
		adx = $unsigned(dx < 0 ? -dx : dx);
		ady = $unsigned(dy < 0 ? -dy : dy);
		lhs_x = {adx, 1'b0};
		lhs_y = {ady, 1'b0};
		rhs_x = (N+2)'(wa) + (N+2)'(wb);
		rhs_y = (N+2)'(ha) + (N+2)'(hb);
	end

	// s2: half-axes of both boxes, exact test for unrotated pairs
	always_ff @(posedge clk) begin
		nx_s2[0] <= $signed({1'b0, wa}) * ca;
		ny_s2[0] <= -($signed({1'b0, wa}) * sa);
		nx_s2[1] <= $signed({1'b0, ha}) * sa;
		ny_s2[1] <= $signed({1'b0, ha}) * ca;
		nx_s2[2] <= $signed({1'b0, wb}) * cb;
		ny_s2[2] <= -($signed({1'b0, wb}) * sb);
		nx_s2[3] <= $signed({1'b0, hb}) * sb;
		ny_s2[3] <= $signed({1'b0, hb}) * cb;
		dx_s2    <= dx;
		dy_s2    <= dy;
		al_s2    <= aligned;
		box_s2   <= (lhs_x <= rhs_x) && (lhs_y <= rhs_y);
	end

	// s3: partial dot products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			ndx_s3[k] <= nx_s2[k] * dx_s2;
			ndy_s3[k] <= ny_s2[k] * dy_s2;
			nnx_s3[k] <= nx_s2[k] * nx_s2[k];
			nny_s3[k] <= ny_s2[k] * ny_s2[k];
		end
		// cross terms: aX.bX, aX.bY, aY.bX, aY.bY
		for (int m = 0; m < 4; m++) begin
			cpx_s3[m] <= nx_s2[m / 2] * nx_s2[2 + (m % 2)];
			cpy_s3[m] <= ny_s2[m / 2] * ny_s2[2 + (m % 2)];
		end
		al_s3  <= al_s2;
		box_s3 <= box_s2;
	end

	logic signed [NDW:0] nd_sum [4];
	logic signed [NNW:0] cp_sum [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nd_sum[k] = (NDW+1)'(ndx_s3[k]) + (NDW+1)'(ndy_s3[k]);
			cp_sum[k] = (NNW+1)'(cpx_s3[k]) + (NNW+1)'(cpy_s3[k]);
		end
	end

	// s4: dot sums and magnitudes
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			nd_s4[k] <= nd_sum[k] < 0 ? -nd_sum[k] : nd_sum[k];
			nn_s4[k] <= (NNW+1)'(nnx_s3[k]) + (NNW+1)'(nny_s3[k]);
			cp_s4[k] <= cp_sum[k] < 0 ? -cp_sum[k] : cp_sum[k];
		end
		al_s4  <= al_s3;
		box_s4 <= box_s3;
	end

	// s5: nearest corner of the other box against each edge, as t > s
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			t_s5[k] <= (SEPW'(nd_s4[k]) <<< (F + 1)) - SEPW'(nn_s4[k]);
		s_s5[0] <= SEPW'(cp_s4[0]) + SEPW'(cp_s4[1]);
		s_s5[1] <= SEPW'(cp_s4[2]) + SEPW'(cp_s4[3]);
		s_s5[2] <= SEPW'(cp_s4[0]) + SEPW'(cp_s4[2]);
		s_s5[3] <= SEPW'(cp_s4[1]) + SEPW'(cp_s4[3]);
		al_s5  <= al_s4;
		box_s5 <= box_s4;
	end

	logic sep;

	always_comb begin
		sep = 1'b0;
		for (int k = 0; k < 4; k++)
			if (t_s5[k] > s_s5[k]) sep = 1'b1;
	end

	always_ff @(posedge clk) begin
		touch_s6 <= al_s5 ? box_s5 : !sep;
	end

	assign touch = touch_s6;

endmodule
`default_nettype wire

// ===== design/spot_crect.sv =====
`default_nettype none
module spot_crect
	import spot_pkg::*;
#(
	parameter int COORD_BITS         = COORD_BITS_DEF,
	parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic signed [COORD_BITS:0]           dx,
	input  logic signed [COORD_BITS:0]           dy,
	input  logic [COORD_BITS-2:0]                cw,
	input  logic [COORD_BITS-2:0]                rw,
	input  logic [COORD_BITS-2:0]                rh,
	input  logic signed [TRIG_FRACTION_BITS+1:0] rc,
	input  logic signed [TRIG_FRACTION_BITS+1:0] rs,
	input  logic                                 rz,
	output logic                                 touch
);
	localparam int N   = COORD_BITS;
	localparam int F   = TRIG_FRACTION_BITS;
	localparam int AW  = N + F + 2;
	localparam int EW  = N + F + 3;
	localparam int CW  = EW + 3;
	localparam int VW  = N + F + 3;
	localparam int DW  = 2 * VW + 1;
	localparam int QW  = VW + AW;
	localparam int C2W = 2 * N - 2;

	typedef struct packed {
		logic alrej;
		logic hit;
		logic rej;
	} crf_t;

	// s2
	logic signed [AW-1:0] axx_s2, axy_s2, ayx_s2, ayy_s2;
	logic signed [EW-1:0] e1a_s2, e1b_s2, e2a_s2, e2b_s2;
	logic [C2W-1:0]       cw2_s2;
	logic [N:0]           lim1_s2, lim2_s2;
	logic                 wnz_s2, hnz_s2, alrej_s2;
	logic signed [N:0]    dx_s2, dy_s2;
	// s3
	logic signed [VW-1:0] vx_s3 [4], vy_s3 [4];
	logic signed [EW:0]   p1_s3, p2_s3;
	logic [N:0]           lim1_s3, lim2_s3;
	logic                 wnz_s3, hnz_s3, alrej_s3;
	logic [C2W-1:0]       cw2_s3;
	logic signed [AW-1:0] axx_s3, axy_s3, ayx_s3, ayy_s3;
	// s4
	logic signed [2*VW-1:0] sqx_s4 [4], sqy_s4 [4];
	logic signed [VW-1:0]   vx_s4 [4], vy_s4 [4];
	logic                   rej_s4, alrej_s4;
	logic [C2W-1:0]         cw2_s4;
	logic signed [AW-1:0]   axx_s4, axy_s4, ayx_s4, ayy_s4;
	// s5
	logic [DW-1:0]          d2_s5 [4];
	logic signed [VW-1:0]   vx_s5 [4], vy_s5 [4];
	crf_t                   f_s5;
	logic signed [AW-1:0]   axx_s5, axy_s5, ayx_s5, ayy_s5;
	// s6
	logic [DW-1:0]          m01_s6, m23_s6;
	logic                   i01_s6, i23_s6;
	logic signed [VW-1:0]   vx_s6 [4], vy_s6 [4];
	crf_t                   f_s6;
	logic signed [AW-1:0]   axx_s6, axy_s6, ayx_s6, ayy_s6;
	// s7
	logic [1:0]             idx_s7;
	logic signed [VW-1:0]   vx_s7 [4], vy_s7 [4];
	crf_t                   f_s7;
	logic signed [AW-1:0]   axx_s7, axy_s7, ayx_s7, ayy_s7;
	// s8
	logic signed [QW-1:0]   q1x_s8, q1y_s8, q2x_s8, q2y_s8;
	logic [1:0]             idx_s8;
	crf_t                   f_s8;
	// s9
	logic                   touch_s9;

	logic [N:0]   adx, ady;
	logic [N+1:0] lhs_x, lhs_y, lim1, lim2;

	always_comb begin
		adx = $unsigned(dx < 0 ? -dx : dx);
		ady = $unsigned(dy < 0 ? -dy : dy);
		lhs_x = {adx, 1'b0};
		lhs_y = {ady, 1'b0};
		lim1 = (N+2)'(rw) + (N+2)'({cw, 1'b0});
		lim2 = (N+2)'(rh) + (N+2)'({cw, 1'b0});
	end

	always_ff @(posedge clk) begin
		axx_s2   <= $signed({1'b0, rw}) * rc;
		axy_s2   <= -($signed({1'b0, rw}) * rs);
		ayx_s2   <= $signed({1'b0, rh}) * rs;
		ayy_s2   <= $signed({1'b0, rh}) * rc;
		e1a_s2   <= rc * dx;
		e1b_s2   <= rs * dy;
		e2a_s2   <= rs * dx;
		e2b_s2   <= rc * dy;
		cw2_s2   <= C2W'(cw) * C2W'(cw);
		lim1_s2  <= lim1[N:0];
		lim2_s2  <= lim2[N:0];
		wnz_s2   <= (rw != '0);
		hnz_s2   <= (rh != '0);
		alrej_s2 <= rz && ((lhs_x > lim1) || (lhs_y > lim2));
		dx_s2    <= dx;
		dy_s2    <= dy;
	end

	// s3: the four corner-to-centre vectors, k = {i, j}
	logic signed [VW-1:0] bx, by;
	logic signed [VW-1:0] cvx [4], cvy [4];

	always_comb begin
		bx = VW'(dx_s2) <<< (F + 1);
		by = VW'(dy_s2) <<< (F + 1);
		for (int k = 0; k < 4; k++) begin
			cvx[k] = bx - ((k >= 2) ? VW'(axx_s2) : -VW'(axx_s2)) -
				((k % 2 == 1) ? VW'(ayx_s2) : -VW'(ayx_s2));
			cvy[k] = by - ((k >= 2) ? VW'(axy_s2) : -VW'(axy_s2)) -
				((k % 2 == 1) ? VW'(ayy_s2) : -VW'(ayy_s2));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			vx_s3[k] <= cvx[k];
			vy_s3[k] <= cvy[k];
		end
		p1_s3    <= (EW+1)'(e1a_s2) - (EW+1)'(e1b_s2);
		p2_s3    <= (EW+1)'(e2a_s2) + (EW+1)'(e2b_s2);
		lim1_s3  <= lim1_s2;
		lim2_s3  <= lim2_s2;
		wnz_s3   <= wnz_s2;
		hnz_s3   <= hnz_s2;
		alrej_s3 <= alrej_s2;
		cw2_s3   <= cw2_s2;
		axx_s3   <= axx_s2;
		axy_s3   <= axy_s2;
		ayx_s3   <= ayx_s2;
		ayy_s3   <= ayy_s2;
	end

	// s4: squared corner distances, edge-side rejects
	logic [CW-1:0] ap1, ap2;

	always_comb begin
		ap1 = CW'($unsigned(p1_s3 < 0 ? -p1_s3 : p1_s3));
		ap2 = CW'($unsigned(p2_s3 < 0 ? -p2_s3 : p2_s3));
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			sqx_s4[k] <= vx_s3[k] * vx_s3[k];
			sqy_s4[k] <= vy_s3[k] * vy_s3[k];
			vx_s4[k]  <= vx_s3[k];
			vy_s4[k]  <= vy_s3[k];
		end
		rej_s4 <= (wnz_s3 && ((ap1 << 1) > (CW'(lim1_s3) << F))) ||
			(hnz_s3 && ((ap2 << 1) > (CW'(lim2_s3) << F)));
		alrej_s4 <= alrej_s3;
		cw2_s4   <= cw2_s3;
		axx_s4   <= axx_s3;
		axy_s4   <= axy_s3;
		ayx_s4   <= ayx_s3;
		ayy_s4   <= ayy_s3;
	end

	// s5: distance sums, any corner inside the circle
	logic [DW-1:0] d2 [4];
	logic [DW-1:0] r2;
	logic          hit;

	always_comb begin
		r2 = DW'(cw2_s4) << (2 * F + 2);
		hit = 1'b0;
		for (int k = 0; k < 4; k++) begin
			d2[k] = $unsigned(DW'(sqx_s4[k]) + DW'(sqy_s4[k]));
			if (d2[k] <= r2) hit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			d2_s5[k] <= d2[k];
			vx_s5[k] <= vx_s4[k];
			vy_s5[k] <= vy_s4[k];
		end
		f_s5   <= '{alrej: alrej_s4, hit: hit, rej: rej_s4};
		axx_s5 <= axx_s4;
		axy_s5 <= axy_s4;
		ayx_s5 <= ayx_s4;
		ayy_s5 <= ayy_s4;
	end

	// s6/s7: closest corner, ties keep the lower index
	always_ff @(posedge clk) begin
		i01_s6 <= d2_s5[1] < d2_s5[0];
		m01_s6 <= (d2_s5[1] < d2_s5[0]) ? d2_s5[1] : d2_s5[0];
		i23_s6 <= d2_s5[3] < d2_s5[2];
		m23_s6 <= (d2_s5[3] < d2_s5[2]) ? d2_s5[3] : d2_s5[2];
		vx_s6  <= vx_s5;
		vy_s6  <= vy_s5;
		f_s6   <= f_s5;
		axx_s6 <= axx_s5;
		axy_s6 <= axy_s5;
		ayx_s6 <= ayx_s5;
		ayy_s6 <= ayy_s5;
	end

	always_ff @(posedge clk) begin
		idx_s7 <= (m23_s6 < m01_s6) ? {1'b1, i23_s6} : {1'b0, i01_s6};
		vx_s7  <= vx_s6;
		vy_s7  <= vy_s6;
		f_s7   <= f_s6;
		axx_s7 <= axx_s6;
		axy_s7 <= axy_s6;
		ayx_s7 <= ayx_s6;
		ayy_s7 <= ayy_s6;
	end

	// s8: closest vector against both half-axes
	always_ff @(posedge clk) begin
		q1x_s8 <= vx_s7[idx_s7] * axx_s7;
		q1y_s8 <= vy_s7[idx_s7] * axy_s7;
		q2x_s8 <= vx_s7[idx_s7] * ayx_s7;
		q2y_s8 <= vy_s7[idx_s7] * ayy_s7;
		idx_s8 <= idx_s7;
		f_s8   <= f_s7;
	end

	// s9: corner-region reject and final verdict
	logic signed [QW:0] dot1, dot2;
	logic               pos1, pos2;

	always_comb begin
		dot1 = (QW+1)'(q1x_s8) + (QW+1)'(q1y_s8);
		dot2 = (QW+1)'(q2x_s8) + (QW+1)'(q2y_s8);
		pos1 = idx_s8[1] ? (dot1 > 0) : (dot1 < 0);
		pos2 = idx_s8[0] ? (dot2 > 0) : (dot2 < 0);
	end

	always_ff @(posedge clk) begin
		touch_s9 <= !f_s8.alrej && (f_s8.hit || !(f_s8.rej || (pos1 && pos2)));
	end

	assign touch = touch_s9;

endmodule
`default_nettype wire

// ===== design/shape_pair_overlap_test_top.sv =====
`default_nettype none
// Pair overlap test for two 2D bodies, each a circle or a rotated rectangle.
// Pulse start with both bodies on the input ports; busy is always low, so an
// item is taken every cycle start is high. Each item returns one result,
// flagged by a one-cycle done pulse with touching valid in that cycle. The
// receiver cannot stall: done is not held, so sample it when it comes. The
// circle-rectangle path is the longest (corner vectors, squared distances, a
// two-level closest-corner pick, then the corner-region dot products); the
// box-box and circle-circle paths are padded to match.
// Throughput is one item per clock. No configuration, no state between items.
module shape_pair_overlap_test_top
	import spot_pkg::*;
#(
	parameter int COORD_BITS         = COORD_BITS_DEF,
	parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [DESC_W-1:0]            a_desc,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic [COORD_BITS-2:0]        a_width,
	input  logic [COORD_BITS-2:0]        a_height,
	input  logic [ANG_W-1:0]             a_angle,
	input  logic [DESC_W-1:0]            b_desc,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic [COORD_BITS-2:0]        b_width,
	input  logic [COORD_BITS-2:0]        b_height,
	input  logic [ANG_W-1:0]             b_angle,
	output logic                         done,
	output logic                         touching
);
	localparam int N  = COORD_BITS;
	localparam int F  = TRIG_FRACTION_BITS;
	localparam int TW = F + 2;
	localparam int CCW = 2 * N + 3;
	localparam int CTL_LAST = 9;   // last stage holding item control
	localparam int CC_DLY   = 6;   // circle pair result s3 -> s9
	localparam int RR_DLY   = 3;   // box pair result s6 -> s9

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---- front: trig lookup, class decode, pair deltas ----
	logic signed [TW-1:0] sa, ca, sb, cb;
	logic                 za, zb;

	spot_trig #(.TRIG_FRACTION_BITS(F)) u_trig_a (
		.angle(a_angle), .sine(sa), .cosine(ca), .is_zero(za)
	);
	spot_trig #(.TRIG_FRACTION_BITS(F)) u_trig_b (
		.angle(b_angle), .sine(sb), .cosine(cb), .is_zero(zb)
	);

	logic a_rect, b_rect, mask_ok;
	cls_t cls;
	logic signed [N:0] dab_x, dab_y;

	always_comb begin
		a_rect = a_desc[SHAPE_BIT];
		b_rect = b_desc[SHAPE_BIT];
		mask_ok = ((a_desc[HIT_LO +: MASK_W] & b_desc[SELF_LO +: MASK_W]) != '0) &&
			((a_desc[SELF_LO +: MASK_W] & b_desc[HIT_LO +: MASK_W]) != '0);
		if (!a_rect && !b_rect) cls = CLS_CC;
		else if (a_rect && b_rect) cls = CLS_RR;
		else cls = CLS_CR;
		dab_x = (N+1)'(a_x) - (N+1)'(b_x);
		dab_y = (N+1)'(a_y) - (N+1)'(b_y);
	end

	ctl_t ctl_s [1:CTL_LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= CTL_LAST; k++) ctl_s[k] <= '0;
		end else begin
			ctl_s[1] <= '{valid: accept, mask_ok: mask_ok, cls: cls};
			for (int k = 2; k <= CTL_LAST; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// stage 1 payload
	logic signed [N:0]    dab_x_s1, dab_y_s1, crd_x_s1, crd_y_s1;
	logic [N-2:0]         wa_s1, ha_s1, wb_s1, hb_s1;
	logic signed [TW-1:0] sa_s1, ca_s1, sb_s1, cb_s1, rs_s1, rc_s1;
	logic                 al_s1, rz_s1;
	logic [N-2:0]         cw_s1, rw_s1, rh_s1;

	always_ff @(posedge clk) begin
		dab_x_s1 <= dab_x;
		dab_y_s1 <= dab_y;
		wa_s1 <= a_width;
		ha_s1 <= a_height;
		wb_s1 <= b_width;
		hb_s1 <= b_height;
		sa_s1 <= sa;
		ca_s1 <= ca;
		sb_s1 <= sb;
		cb_s1 <= cb;
		al_s1 <= za && zb;
		// circle against rectangle: whichever body is the circle goes first
		if (!a_rect) begin
			crd_x_s1 <= dab_x;
			crd_y_s1 <= dab_y;
			cw_s1 <= a_width;
			rw_s1 <= b_width;
			rh_s1 <= b_height;
			rs_s1 <= sb;
			rc_s1 <= cb;
			rz_s1 <= zb;
		end else begin
			crd_x_s1 <= -dab_x;
			crd_y_s1 <= -dab_y;
			cw_s1 <= b_width;
			rw_s1 <= a_width;
			rh_s1 <= a_height;
			rs_s1 <= sa;
			rc_s1 <= ca;
			rz_s1 <= za;
		end
	end

	// ---- circle pair: squared distance vs squared radius sum ----
	logic signed [2*N+1:0] sqx_s2, sqy_s2;
	logic [N-1:0]          rsum;
	logic [2*N-1:0]        rs2_s2;
	logic                  cc_s3;
	logic [CC_DLY-1:0]     cc_dly_q;

	assign rsum = N'(wa_s1) + N'(wb_s1);

	always_ff @(posedge clk) begin
		sqx_s2 <= dab_x_s1 * dab_x_s1;
		sqy_s2 <= dab_y_s1 * dab_y_s1;
		rs2_s2 <= (2*N)'(rsum) * (2*N)'(rsum);
		cc_s3  <= (CCW'(sqx_s2) + CCW'(sqy_s2)) <= $signed({3'b000, rs2_s2});
		cc_dly_q <= {cc_dly_q[CC_DLY-2:0], cc_s3};
	end

	// ---- box pair ----
	logic              rr_s6;
	logic [RR_DLY-1:0] rr_dly_q;

	spot_rect #(.COORD_BITS(N), .TRIG_FRACTION_BITS(F)) u_rect (
		.clk(clk), .dx(dab_x_s1), .dy(dab_y_s1),
		.wa(wa_s1), .ha(ha_s1), .wb(wb_s1), .hb(hb_s1),
		.ca(ca_s1), .sa(sa_s1), .cb(cb_s1), .sb(sb_s1),
		.aligned(al_s1), .touch(rr_s6)
	);

	always_ff @(posedge clk) begin
		rr_dly_q <= {rr_dly_q[RR_DLY-2:0], rr_s6};
	end

	// ---- circle against box ----
	logic cr_s9;

	spot_crect #(.COORD_BITS(N), .TRIG_FRACTION_BITS(F)) u_crect (
		.clk(clk), .dx(crd_x_s1), .dy(crd_y_s1), .cw(cw_s1),
		.rw(rw_s1), .rh(rh_s1), .rc(rc_s1), .rs(rs_s1), .rz(rz_s1),
		.touch(cr_s9)
	);

	// ---- result select ----
	logic sel;
	logic done_s10, touching_s10;

	always_comb begin
		case (ctl_s[CTL_LAST].cls)
			CLS_CC:  sel = cc_dly_q[CC_DLY-1];
			CLS_RR:  sel = rr_dly_q[RR_DLY-1];
			default: sel = cr_s9;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s10 <= 1'b0;
		end else begin
			done_s10 <= ctl_s[CTL_LAST].valid;
		end
	end

	always_ff @(posedge clk) begin
		touching_s10 <= ctl_s[CTL_LAST].mask_ok && sel;
	end

	assign done     = done_s10;
	assign touching = touching_s10;

	// ---- checks ----
	a_item_returns: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##10 done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 10))
		else $error("result without an accepted item");

	a_mask_gate: assert property (@(posedge clk) disable iff (!arst_n)
		done && touching |-> $past(mask_ok, 10))
		else $error("touch reported for mismatched masks");

endmodule
`default_nettype wire

// ===== sim/shape_pair_overlap_test_top_tb.sv =====
`timescale 1ns / 100ps
module shape_pair_overlap_test_top_tb;
	import spot_pkg::*;

	localparam int CB      = COORD_BITS_DEF;
	localparam int TFB     = TRIG_FRAC_DEF;
	localparam int LIMIT   = 400000;
	localparam int N_RAND  = 1630;
	localparam int TAIL    = 200;    // last items go out with no idling
	localparam int SETTLE  = 30;     // cycles after the last result
	localparam bit SHAPE_CIRCLE = 1'b0;
	localparam bit SHAPE_RECT   = 1'b1;

	typedef logic signed [127:0] wide_t;

	// one body as it sits on the ports
	typedef struct {
		logic [DESC_W-1:0]    desc;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic [CB-2:0]        w;
		logic [CB-2:0]        h;
		logic [ANG_W-1:0]     ang;
	} body_in_t;

	typedef struct {
		body_in_t a;
		body_in_t b;
		bit       drain;    // sender holds off until all results are back
	} pair_t;

	// body worked out at the scaled units used for the geometry
	typedef struct {
		bit          rect;
		logic [7:0]  self_m;
		logic [7:0]  hit_m;
		int          ang;
		longint      x, y, w, h, c, s;
		longint      px, py, axx, axy, ayx, ayy, r;
	} geo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic touching;
	body_in_t drv_a = '{default: '0};
	body_in_t drv_b = '{default: '0};

	pair_t pending_pairs[$];
	bit    touch_expected[$];
	pair_t on_ports;
	int    gap_left = 0;
	int    cycle_cnt = 0;
	int    fail_cnt = 0;
	int    result_cnt = 0;
	int    touch_cnt = 0;
	int    kind_cnt[3] = '{0, 0, 0};   // by number of boxes in the pair
	bit    stim_done = 1'b0;

	shape_pair_overlap_test_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.a_desc   (drv_a.desc),
		.a_x      (drv_a.x),
		.a_y      (drv_a.y),
		.a_width  (drv_a.w),
		.a_height (drv_a.h),
		.a_angle  (drv_a.ang),
		.b_desc   (drv_b.desc),
		.b_x      (drv_b.x),
		.b_y      (drv_b.y),
		.b_width  (drv_b.w),
		.b_height (drv_b.h),
		.b_angle  (drv_b.ang),
		.done     (done),
		.touching (touching)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	// sine of a whole degree, Q14, Taylor series to x^13 at Q30
	function automatic longint sin_deg(input int deg);
		longint unsigned x, x2, term, acc;
		int q;
		bit neg;
		q = deg;
		neg = 1'b0;
		if (q >= ANG_HALF) begin
			q = q - ANG_HALF;
			neg = 1'b1;
		end
		if (q > ANG_QTR) q = ANG_HALF - q;
		x = (longint'(q) * PI_Q30) / 64'd180;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		acc = (acc + (64'd1 << (29 - TFB))) >> (30 - TFB);
		return neg ? -longint'(acc) : longint'(acc);
	endfunction

	function automatic geo_t to_geo(input body_in_t bi);
		geo_t g;
		longint k;
		k = longint'(1) << (TFB + 1);
		g.rect = bi.desc[SHAPE_BIT];
		g.self_m = bi.desc[SELF_LO +: MASK_W];
		g.hit_m = bi.desc[HIT_LO +: MASK_W];
		g.x = bi.x;
		g.y = bi.y;
		g.w = longint'(bi.w);
		g.h = longint'(bi.h);
		g.ang = int'(bi.ang);
		if (g.ang >= ANG_FULL) g.ang = g.ang - ANG_FULL;
		g.s = sin_deg(g.ang);
		g.c = sin_deg((g.ang + ANG_QTR) % ANG_FULL);
		g.px = g.x * k;
		g.py = g.y * k;
		g.axx = g.w * g.c;
		g.axy = -(g.w * g.s);
		g.ayx = g.h * g.s;
		g.ayy = g.h * g.c;
		g.r = g.w * k;
		return g;
	endfunction

	function automatic wide_t dot2(input longint ux, uy, vx, vy);
		wide_t a, b, c, d;
		a = ux; b = uy; c = vx; d = vy;
		return a * c + b * d;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// every corner of o lies strictly outside the edge of e with normal (nx, ny)
	function automatic bit corners_outside(input longint nx, ny, input geo_t e, input geo_t o);
		longint vx, vy;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++) begin
				vx = o.px + (i ? o.axx : -o.axx) + (j ? o.ayx : -o.ayx);
				vy = o.py + (i ? o.axy : -o.axy) + (j ? o.ayy : -o.ayy);
				if (!(dot2(nx, ny, vx - (e.px + nx), vy - (e.py + ny)) > 0)) return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic bit edge_splits(input geo_t e, input geo_t o);
		return corners_outside(e.axx, e.axy, e, o) || corners_outside(-e.axx, -e.axy, e, o) ||
			corners_outside(e.ayx, e.ayy, e, o) || corners_outside(-e.ayx, -e.ayy, e, o);
	endfunction

	function automatic bit box_box(input geo_t a, input geo_t b);
		if (a.ang == 0 && b.ang == 0)
			return 2 * mag(a.x - b.x) <= a.w + b.w && 2 * mag(a.y - b.y) <= a.h + b.h;
		return !edge_splits(a, b) && !edge_splits(b, a);
	endfunction

	function automatic bit disc_box(input geo_t ci, input geo_t re);
		longint dx, dy, p, sc, ex_x, ex_y, ey_x, ey_y, vx, vy;
		longint v0x, v0y, s1x, s1y, s2x, s2y;
		wide_t r2, d2, best;
		bit have;
		dx = ci.x - re.x;
		dy = ci.y - re.y;
		sc = longint'(1) << TFB;
		r2 = dot2(ci.r, 0, ci.r, 0);
		best = '0;
		have = 1'b0;
		v0x = 0; v0y = 0; s1x = 0; s1y = 0; s2x = 0; s2y = 0;
		if (re.ang == 0) begin
			if (2 * mag(dx) > 2 * ci.w + re.w) return 1'b0;
			if (2 * mag(dy) > 2 * ci.w + re.h) return 1'b0;
		end
		// corners in order -X-Y, -X+Y, +X-Y, +X+Y; ties keep the earlier one
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++) begin
				ex_x = i ? re.axx : -re.axx;
				ex_y = i ? re.axy : -re.axy;
				ey_x = j ? re.ayx : -re.ayx;
				ey_y = j ? re.ayy : -re.ayy;
				vx = ci.px - (re.px + ex_x + ey_x);
				vy = ci.py - (re.py + ex_y + ey_y);
				d2 = dot2(vx, vy, vx, vy);
				if (d2 <= r2) return 1'b1;
				if (!have || d2 < best) begin
					have = 1'b1; best = d2;
					v0x = vx; v0y = vy; s1x = ex_x; s1y = ex_y; s2x = ey_x; s2y = ey_y;
				end
			end
		p = 2 * (re.c * dx - re.s * dy);
		if (re.w > 0 && mag(p) > (re.w + 2 * ci.w) * sc) return 1'b0;
		p = 2 * (re.s * dx + re.c * dy);
		if (re.h > 0 && mag(p) > (re.h + 2 * ci.w) * sc) return 1'b0;
		if (dot2(v0x, v0y, s1x, s1y) > 0 && dot2(v0x, v0y, s2x, s2y) > 0) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit pair_touches(input pair_t pr);
		geo_t a, b;
		wide_t d2, rs2;
		a = to_geo(pr.a);
		b = to_geo(pr.b);
		if ((a.hit_m & b.self_m) == 0 || (a.self_m & b.hit_m) == 0) return 1'b0;
		if (!a.rect && !b.rect) begin
			d2 = dot2(a.x - b.x, a.y - b.y, a.x - b.x, a.y - b.y);
			rs2 = dot2(a.w + b.w, 0, a.w + b.w, 0);
			return d2 <= rs2;
		end
		if (a.rect && b.rect) return box_box(a, b);
		if (!a.rect) return disc_box(a, b);
		return disc_box(b, a);
	endfunction

	// ---------------- stimulus ----------------

	function automatic body_in_t mk_body(input bit shp, input logic [7:0] sm, hm,
		input int x, y, w, h, ang);
		body_in_t bi;
		bi.desc = {hm, sm, shp};
		bi.x = x[CB-1:0];
		bi.y = y[CB-1:0];
		bi.w = w[CB-2:0];
		bi.h = h[CB-2:0];
		bi.ang = ang[ANG_W-1:0];
		return bi;
	endfunction

	function automatic int pick_angle();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 0;
		if (r < 5) return 90 * $urandom_range(0, 3);
		if (r == 5) return $urandom_range(360, 511);   // wraps modulo 360
		return $urandom_range(0, 359);
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(0, 32767);
		return $urandom_range(0, 3000);
	endfunction

	function automatic pair_t rand_pair();
		pair_t pr;
		logic [7:0] sa, sb, ha, hb;
		int ax, ay, aw, ah, bw, bh, reach;
		sa = 8'($urandom_range(1, 255));
		sb = 8'($urandom_range(1, 255));
		ha = 8'($urandom_range(0, 255)) | sb;
		hb = 8'($urandom_range(0, 255)) | sa;
		aw = pick_size(); ah = pick_size(); bw = pick_size(); bh = pick_size();
		pr.drain = 1'b0;
		if ($urandom_range(0, 9) < 8) begin
			// neighbors: offset on the scale of the bodies so both outcomes come up
			ax = $urandom_range(0, 32000) - 16000;
			ay = $urandom_range(0, 32000) - 16000;
			reach = (aw + ah + bw + bh) / 2 + 16;
			if (reach > 16000) reach = 16000;
			pr.a = mk_body($urandom_range(0, 1), sa, ha, ax, ay, aw, ah, pick_angle());
			pr.b = mk_body($urandom_range(0, 1), sb, hb,
				ax + $urandom_range(0, 2 * reach) - reach,
				ay + $urandom_range(0, 2 * reach) - reach, bw, bh, pick_angle());
		end else begin
			pr.a.desc = DESC_W'($urandom); pr.a.x = CB'($urandom); pr.a.y = CB'($urandom);
			pr.a.w = (CB-1)'($urandom); pr.a.h = (CB-1)'($urandom);
			pr.a.ang = ANG_W'($urandom);
			pr.b.desc = DESC_W'($urandom); pr.b.x = CB'($urandom); pr.b.y = CB'($urandom);
			pr.b.w = (CB-1)'($urandom); pr.b.h = (CB-1)'($urandom);
			pr.b.ang = ANG_W'($urandom);
		end
		return pr;
	endfunction

	task automatic add_pair(input body_in_t a, input body_in_t b);
		pair_t pr;
		pr.a = a;
		pr.b = b;
		pr.drain = 1'b0;
		pending_pairs.push_back(pr);
	endtask

	initial begin
		pair_t pr;
		// directed: every class, mask mismatch, extremes, wrap angles, zero sizes
		add_pair(mk_body(SHAPE_CIRCLE, 8'h01, 8'h01, 0, 0, 100, 0, 0),
			mk_body(SHAPE_CIRCLE, 8'h01, 8'h01, 200, 0, 100, 0, 0));
		add_pair(mk_body(SHAPE_CIRCLE, 8'h01, 8'h01, 0, 0, 100, 0, 0),
			mk_body(SHAPE_CIRCLE, 8'h01, 8'h01, 201, 0, 100, 0, 0));
		add_pair(mk_body(SHAPE_CIRCLE, 8'h01, 8'h02, 0, 0, 100, 0, 0),
			mk_body(SHAPE_CIRCLE, 8'h01, 8'h01, 0, 0, 100, 0, 0));
		add_pair(mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 0, 0, 200, 100, 0),
			mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 200, 100, 200, 100, 0));
		add_pair(mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 0, 0, 200, 100, 0),
			mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 201, 0, 200, 100, 0));
		add_pair(mk_body(SHAPE_RECT, 8'h80, 8'h80, 0, 0, 400, 100, 45),
			mk_body(SHAPE_RECT, 8'h80, 8'h80, 250, 250, 400, 100, 135));
		add_pair(mk_body(SHAPE_RECT, 8'h80, 8'h80, 0, 0, 400, 100, 30),
			mk_body(SHAPE_RECT, 8'h80, 8'h80, 100, 0, 50, 50, 0));
		add_pair(mk_body(SHAPE_CIRCLE, 8'h10, 8'h10, 0, 0, 50, 0, 0),
			mk_body(SHAPE_RECT, 8'h10, 8'h10, 100, 100, 100, 100, 0));
		add_pair(mk_body(SHAPE_RECT, 8'h10, 8'h10, 100, 100, 100, 100, 45),
			mk_body(SHAPE_CIRCLE, 8'h10, 8'h10, 0, 0, 80, 0, 0));
		add_pair(mk_body(SHAPE_CIRCLE, 8'h10, 8'h10, 0, 0, 60, 0, 0),
			mk_body(SHAPE_RECT, 8'h10, 8'h10, 95, 95, 100, 100, 10));
		add_pair(mk_body(SHAPE_CIRCLE, 8'h10, 8'h10, 0, 0, 0, 0, 0),
			mk_body(SHAPE_RECT, 8'h10, 8'h10, 0, 0, 0, 0, 0));
		add_pair(mk_body(SHAPE_RECT, 8'h10, 8'h10, 0, 0, 0, 500, 359),
			mk_body(SHAPE_CIRCLE, 8'h10, 8'h10, 30, 0, 20, 0, 0));
		add_pair(mk_body(SHAPE_RECT, 8'h01, 8'h01, 0, 0, 300, 300, 360),
			mk_body(SHAPE_RECT, 8'h01, 8'h01, 300, 0, 300, 300, 511));
		add_pair(mk_body(SHAPE_CIRCLE, 8'hFF, 8'hFF, -32768, -32768, 32767, 32767, 0),
			mk_body(SHAPE_CIRCLE, 8'hFF, 8'hFF, 32767, 32767, 32767, 32767, 0));
		add_pair(mk_body(SHAPE_RECT, 8'hFF, 8'hFF, -32768, 32767, 32767, 32767, 270),
			mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 32767, -32768, 32767, 32767, 180));
		add_pair(mk_body(SHAPE_CIRCLE, 8'hFF, 8'hFF, -32768, 0, 32767, 0, 90),
			mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 32767, 0, 32767, 32767, 1));
		add_pair(mk_body(SHAPE_RECT, 8'hAA, 8'h55, 0, 0, 100, 100, 0),
			mk_body(SHAPE_RECT, 8'hAA, 8'h55, 0, 0, 100, 100, 0));
		add_pair(mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 0, 0, 32767, 0, 0),
			mk_body(SHAPE_RECT, 8'hFF, 8'hFF, 0, 0, 0, 32767, 0));
		for (int n = 0; n < N_RAND; n++) begin
			pr = rand_pair();
			pr.drain = (n == N_RAND / 3) || (n == 2 * N_RAND / 3);
			pending_pairs.push_back(pr);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_done);
		wait (touch_expected.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d pairs: %0d circle-circle, %0d box-box, %0d circle-box;",
			result_cnt, kind_cnt[0], kind_cnt[2], kind_cnt[1]);
		$display("%0d of them touching.", touch_cnt);
		if (fail_cnt == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			// an item on the ports with start high and busy low was taken at this edge
			if (start && !busy) begin
				touch_expected.push_back(pair_touches(on_ports));
				kind_cnt[int'(on_ports.a.desc[SHAPE_BIT]) +
					int'(on_ports.b.desc[SHAPE_BIT])]++;
				void'(pending_pairs.pop_front());
			end
			if (pending_pairs.size() == 0) begin
				start <= 1'b0;
				stim_done <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_pairs[0].drain && (touch_expected.size() != 0 ||
				(start && !busy))) begin
				// hold off until the pipeline has emptied
				start <= 1'b0;
			end else if (pending_pairs.size() > TAIL && $urandom_range(0, 5) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 3);
			end else begin
				on_ports <= pending_pairs[0];
				drv_a <= pending_pairs[0].a;
				drv_b <= pending_pairs[0].b;
				start <= 1'b1;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (touch_expected.size() == 0) begin
				$error("touching: result with no item outstanding, actual %0b", touching);
				fail_cnt++;
			end else begin
				if (touching !== touch_expected[0]) begin
					$error("touching: expected %0b, actual %0b", touch_expected[0], touching);
					fail_cnt++;
				end
				touch_cnt += touch_expected[0];
				result_cnt++;
				void'(touch_expected.pop_front());
			end
		end
	end

endmodule

// ===== files.f =====
design/spot_pkg.sv
design/spot_trig.sv
design/spot_rect.sv
design/spot_crect.sv
design/shape_pair_overlap_test_top.sv
sim/shape_pair_overlap_test_top_tb.sv
